// File: rtl/core/ath_pkg.sv
// Shared types and constants of the audio-to-haptic high-pass block.
// Used by the configuration registers, the controller, the datapath and the top level.
// Depends on nothing.
package ath_pkg;

  localparam int SAMPLE_W    = 16;  // Q1.15 audio sample
  localparam int GAIN_W      = 16;  // Q4.12 volume gain
  localparam int GAIN_FRAC   = 12;
  localparam int ALPHA_W     = 16;  // Q0.16 smoothing factor
  localparam int ALPHA_FRAC  = 16;
  localparam int DEC_W       = 7;
  localparam int PHASE_W     = 6;
  localparam int DEC_MAX     = 64;
  localparam int SLOT_W      = 6;
  localparam int X_W         = SAMPLE_W + GAIN_W + 1 - GAIN_FRAC;  // gained sample
  localparam int HAPTIC_FRAC = 15;
  localparam int HAPTIC_SCALE = 127;
  localparam int INT8_MIN    = -128;
  localparam int ROUND_BIAS  = (1 << HAPTIC_FRAC) - 1;

  localparam int IN_DATA_W   = 2 * SAMPLE_W;
  localparam int OUT_DATA_W  = 72;  // four samples and the slot, padded to bytes

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_WIRELESS_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_GAIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_WIRED    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_WIRELESS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DECIMATION     = 3'd4;

  localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd4096;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd32768;
  localparam logic [DEC_W-1:0]   DEC_RESET   = 7'd16;

  typedef struct packed {
    logic               wireless;
    logic [GAIN_W-1:0]  gain;
    logic [ALPHA_W-1:0] alpha_wired;
    logic [ALPHA_W-1:0] alpha_wireless;
    logic [DEC_W-1:0]   decimation;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              load_in;
    logic              gain;
    logic              mul;
    logic              acc;
    logic              hp;
    logic              emit_res;
    logic              emit_pad;
    logic [SLOT_W-1:0] slot;
    logic              pkt_last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

// File: rtl/core/ath_cfg.sv
// Configuration register file of the audio-to-haptic block.
// Depends on ath_pkg for the register indexes, reset values and cfg_t.
module ath_cfg
  import ath_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  cfg_ready_o,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_WIRELESS_MODE:  cfg_d.wireless       = cfg_data_i[0];
        CFG_VOLUME_GAIN:    cfg_d.gain           = cfg_data_i;
        CFG_ALPHA_WIRED:    cfg_d.alpha_wired    = cfg_data_i;
        CFG_ALPHA_WIRELESS: cfg_d.alpha_wireless = cfg_data_i;
        CFG_DECIMATION:     cfg_d.decimation     = cfg_data_i[DEC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wireless       <= 1'b0;
      cfg_q.gain           <= GAIN_RESET;
      cfg_q.alpha_wired    <= ALPHA_RESET;
      cfg_q.alpha_wireless <= ALPHA_RESET;
      cfg_q.decimation     <= DEC_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/core/ath_ctrl.sv
// Controller of the audio-to-haptic block: frame sequencing, decimation phase,
// slot and packet counters, and zero padding. Depends on ath_pkg.
module ath_ctrl
  import ath_pkg::*;
#(
  parameter int PACKET_PAIRS       = 32,
  parameter int PACKETS_PER_BUFFER = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic s_valid_i,
  input  logic s_first_i,
  input  logic s_last_i,
  output logic s_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam int TOTAL_SLOTS = PACKET_PAIRS * PACKETS_PER_BUFFER;
  localparam int PAIRS_W     = $clog2(TOTAL_SLOTS + 1);
  localparam int POS_W       = (PACKET_PAIRS > 1) ? $clog2(PACKET_PAIRS) : 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_GAIN = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_ACC  = 3'd3;
  localparam logic [2:0] ST_HP   = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;
  localparam logic [2:0] ST_PAD  = 3'd6;

  logic [2:0]         state_q, state_d;
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [PAIRS_W-1:0] pairs_q, pairs_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic               last_q, last_d;

  logic [PHASE_W-1:0] phase_eff;
  logic [PAIRS_W-1:0] pairs_eff;
  logic [POS_W-1:0]   pos_eff;
  logic [DEC_W-1:0]   dec_eff;
  logic               room;
  logic [POS_W-1:0]   pos_inc;

  function automatic logic [PHASE_W-1:0] next_phase(input logic [PHASE_W-1:0] p,
                                                    input logic [DEC_W-1:0] d);
    logic [DEC_W-1:0] n;
    n = DEC_W'(p) + DEC_W'(1);
    return (n >= d) ? '0 : n[PHASE_W-1:0];
  endfunction

  // A decimation of zero acts as one, anything above the maximum as the maximum.
  assign dec_eff = (cfg_i.decimation == '0) ? DEC_W'(1) :
                   (cfg_i.decimation > DEC_W'(DEC_MAX)) ? DEC_W'(DEC_MAX) :
                   cfg_i.decimation;

  // A first frame clears the counters before the frame itself is handled.
  assign phase_eff = s_first_i ? '0 : phase_q;
  assign pairs_eff = s_first_i ? '0 : pairs_q;
  assign pos_eff   = s_first_i ? '0 : pos_q;

  assign room    = pairs_q < PAIRS_W'(TOTAL_SLOTS);
  assign pos_inc = (pos_q == POS_W'(PACKET_PAIRS - 1)) ? '0 : pos_q + POS_W'(1);

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    pairs_d = pairs_q;
    pos_d   = pos_q;
    last_d  = last_q;
    cmd_o   = '0;
    cmd_o.slot     = cfg_i.wireless ? SLOT_W'(pairs_q) : '0;
    cmd_o.pkt_last = cfg_i.wireless && (pos_q == POS_W'(PACKET_PAIRS - 1));
    s_ready_o = (state_q == ST_IDLE);

    case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          cmd_o.load_in = 1'b1;
          last_d  = s_last_i;
          phase_d = phase_eff;
          pairs_d = pairs_eff;
          pos_d   = pos_eff;
          if (!cfg_i.wireless || phase_eff == '0) begin
            state_d = ST_GAIN;
          end else begin
            phase_d = next_phase(phase_eff, dec_eff);
            state_d = s_last_i ? ST_PAD : ST_IDLE;
          end
        end
      end
      ST_GAIN: begin
        cmd_o.gain = 1'b1;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        state_d = ST_HP;
      end
      ST_HP: begin
        cmd_o.hp = 1'b1;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!cfg_i.wireless) begin
          if (sts_i.out_free) begin
            cmd_o.emit_res = 1'b1;
            state_d = ST_IDLE;
          end
        end else if (!room) begin
          // Buffer is full: the pair is dropped, the filter has still moved on.
          phase_d = next_phase(phase_q, dec_eff);
          state_d = last_q ? ST_PAD : ST_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.emit_res = 1'b1;
          pairs_d = pairs_q + PAIRS_W'(1);
          pos_d   = pos_inc;
          phase_d = next_phase(phase_q, dec_eff);
          state_d = last_q ? ST_PAD : ST_IDLE;
        end
      end
      ST_PAD: begin
        if (!room) begin
          state_d = ST_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.emit_pad = 1'b1;
          pairs_d = pairs_q + PAIRS_W'(1);
          pos_d   = pos_inc;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= '0;
      pairs_q <= '0;
      pos_q   <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      pairs_q <= pairs_d;
      pos_q   <= pos_d;
      last_q  <= last_d;
    end
  end

endmodule

// File: rtl/core/ath_dp.sv
// Datapath of the audio-to-haptic block: gain, one-pole low-pass per channel,
// high-pass difference, output formatting and the output register. Depends on ath_pkg.
module ath_dp
  import ath_pkg::*;
#(
  parameter int STATE_WIDTH = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o,
  input  logic [IN_DATA_W-1:0]  s_data_i,
  input  logic                  m_ready_i,
  output logic                  m_valid_o,
  output logic [OUT_DATA_W-1:0] m_data_o
);

  localparam int SW   = STATE_WIDTH;
  localparam int OMA_W = ALPHA_W + 1;                       // 65536 - alpha
  localparam int P1_W = X_W + OMA_W + 1;
  localparam int P2_W = SW + ALPHA_W + 1;
  localparam int AW   = ((P1_W > P2_W) ? P1_W : P2_W) + 1;
  localparam int SH_W = AW - ALPHA_FRAC;
  localparam int HW   = ((SW > X_W) ? SW : X_W) + 1;
  localparam int VW   = HW + 8;
  localparam int GP_W = SAMPLE_W + GAIN_W + 1;

  localparam logic signed [VW-1:0] V_HI = VW'(HAPTIC_SCALE * (1 << HAPTIC_FRAC));
  localparam logic signed [VW-1:0] V_LO = VW'(INT8_MIN * (1 << HAPTIC_FRAC));

  logic [ALPHA_W-1:0] alpha;
  logic [OMA_W-1:0]   one_minus;
  logic               out_valid_q;
  logic [SLOT_W-1:0]  slot_q;
  logic               plast_q;
  logic               load_out;

  logic signed [SAMPLE_W-1:0] audio_q [2];
  logic signed [SAMPLE_W-1:0] haptic_q [2];

  assign alpha     = cfg_i.wireless ? cfg_i.alpha_wireless : cfg_i.alpha_wired;
  assign one_minus = {1'b1, {ALPHA_W{1'b0}}} - OMA_W'(alpha);
  assign load_out  = cmd_i.emit_res || cmd_i.emit_pad;
  assign sts_o.out_free = !out_valid_q || m_ready_i;

  for (genvar i = 0; i < 2; i++) begin : g_lane
    logic signed [SAMPLE_W-1:0] sample_q;
    logic signed [X_W-1:0]      x_q;
    logic signed [P1_W-1:0]     p1_q;
    logic signed [P2_W-1:0]     p2_q;
    logic signed [SW-1:0]       lp_q;
    logic signed [HW-1:0]       hp_q;

    logic signed [GP_W-1:0] gprod;
    logic signed [X_W-1:0]  x_d;
    logic signed [AW-1:0]   acc;
    logic signed [SH_W-1:0] shifted;
    logic [SH_W-SW:0]       top;
    logic signed [SW-1:0]   lp_d;
    logic signed [VW-1:0]   v, vc, adj;
    logic [7:0]             h8;
    logic [SAMPLE_W-1:0]    audio_d, haptic_d;
    logic [X_W-SAMPLE_W:0]  x_top;
    logic [HW-SAMPLE_W:0]   hp_top;

    // Floor of sample * gain / 4096 is the arithmetic shift of the product.
    assign gprod = sample_q * $signed({1'b0, cfg_i.gain});
    assign x_d   = cfg_i.wireless ? X_W'(sample_q) : gprod[GP_W-1:GAIN_FRAC];

    assign acc     = AW'(p1_q) + AW'(p2_q);
    assign shifted = acc[AW-1:ALPHA_FRAC];
    assign top     = shifted[SH_W-1:SW-1];
    assign lp_d    = (&top || ~|top) ? shifted[SW-1:0] :
                     {shifted[SH_W-1], {(SW-1){~shifted[SH_W-1]}}};

    // Haptic int8: times 127 as a shift and subtract, clamp, then truncate toward zero.
    assign v   = (VW'(hp_q) <<< 7) - VW'(hp_q);
    assign vc  = (v < V_LO) ? V_LO : ((v > V_HI) ? V_HI : v);
    assign adj = vc + (vc[VW-1] ? VW'(ROUND_BIAS) : VW'(0));
    assign h8  = adj[HAPTIC_FRAC+7:HAPTIC_FRAC];

    assign x_top  = x_q[X_W-1:SAMPLE_W-1];
    assign hp_top = hp_q[HW-1:SAMPLE_W-1];

    always_comb begin
      audio_d  = '0;
      haptic_d = '0;
      if (cmd_i.emit_res) begin
        if (cfg_i.wireless) begin
          haptic_d = {{(SAMPLE_W-8){h8[7]}}, h8};
        end else begin
          audio_d  = (&x_top || ~|x_top) ? x_q[SAMPLE_W-1:0] :
                     {x_q[X_W-1], {(SAMPLE_W-1){~x_q[X_W-1]}}};
          haptic_d = (&hp_top || ~|hp_top) ? hp_q[SAMPLE_W-1:0] :
                     {hp_q[HW-1], {(SAMPLE_W-1){~hp_q[HW-1]}}};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.load_in) sample_q <= s_data_i[i*SAMPLE_W +: SAMPLE_W];
      if (cmd_i.gain)    x_q <= x_d;
      if (cmd_i.mul) begin
        p1_q <= $signed({1'b0, one_minus}) * x_q;
        p2_q <= $signed({1'b0, alpha}) * lp_q;
      end
      if (cmd_i.hp)      hp_q <= HW'(x_q) - HW'(lp_q);
      if (load_out) begin
        audio_q[i]  <= audio_d;
        haptic_q[i] <= haptic_d;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        lp_q <= '0;
      end else if (cmd_i.acc) begin
        lp_q <= lp_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      slot_q  <= cmd_i.slot;
      plast_q <= cmd_i.pkt_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_data_o  = {{(OUT_DATA_W - 4*SAMPLE_W - SLOT_W - 1){1'b0}}, plast_q, slot_q,
                      haptic_q[1], haptic_q[0], audio_q[1], audio_q[0]};

endmodule

// File: rtl/core/audio_to_haptic_highpass.sv
// Top level of the audio-to-haptic high-pass block.
// Depends on ath_pkg, ath_cfg, ath_ctrl and ath_dp.
//
// Stereo Q1.15 frames come in on the s_axis stream and feed a one-pole
// low-pass per channel; the haptic output is the filter input minus the new
// low-pass state. In wired mode every frame is scaled by the Q4.12 volume
// gain and gives one word carrying clamped audio and clamped haptic. In
// wireless mode one frame in every `decimation` is kept and gives an int8
// haptic pair in a numbered slot of a buffer of PACKETS_PER_BUFFER packets of
// PACKET_PAIRS pairs, with tlast on the last pair of each packet; a frame
// flagged last pads the rest of the buffer with zero pairs. Frames are
// handled one at a time: an accepted frame passes through gain, the two
// low-pass multiplies, accumulate and saturate, difference and formatting,
// then the controller returns to idle for the next frame. Each stage of
// that chain is one registered step of the shared datapath. A frame skipped
// by decimation leaves the controller idle, or starts padding if flagged
// last; padding emits zero pairs until the buffer is full, then returns to
// idle. A word still held on m_axis stalls the formatting and padding steps.
// The output register lets the next frame be accepted while the previous
// word still waits on m_axis. Configuration is to be written over the cfg
// port only while no frame is in flight, which the block does not enforce.
module audio_to_haptic_highpass
  import ath_pkg::*;
#(
  parameter int PACKET_PAIRS       = 32,
  parameter int PACKETS_PER_BUFFER = 2,
  parameter int STATE_WIDTH        = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,

  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // left_sample [15:0], right_sample [31:16]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // first_frame [0]
  input  logic                  s_axis_tuser,
  input  logic                  s_axis_tlast,

  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // audio_left [15:0], audio_right [31:16], haptic_left [47:32],
  // haptic_right [63:48], slot [69:64], zeros [71:70]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tlast
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;
  logic [OUT_DATA_W-1:0] dp_data;

  ath_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_o       (cfg)
  );

  ath_ctrl #(
    .PACKET_PAIRS       (PACKET_PAIRS),
    .PACKETS_PER_BUFFER (PACKETS_PER_BUFFER)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .s_valid_i (s_axis_tvalid),
    .s_first_i (s_axis_tuser),
    .s_last_i  (s_axis_tlast),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  ath_dp #(
    .STATE_WIDTH (STATE_WIDTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .s_data_i  (s_axis_tdata),
    .m_ready_i (m_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_data_o  (dp_data)
  );

  // The packet-last flag rides in the top padding bits of the datapath word.
  assign m_axis_tlast = dp_data[OUT_DATA_W-2];
  assign m_axis_tdata = {2'b00, dp_data[OUT_DATA_W-3:0]};

  // Packet boundaries only occur on the wireless path, where audio is muted.
  a_tlast_muted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[31:0] == 32'd0)
    else $error("packet end word carries audio");

  // A nonzero slot number is wireless, so audio must be zero.
  a_slot_muted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[69:64] != 6'd0) |-> m_axis_tdata[31:0] == 32'd0)
    else $error("slotted word carries audio");

  // Wireless haptics stay within the int8 range.
  a_int8_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tlast || (m_axis_tdata[69:64] != 6'd0)) |->
      (&m_axis_tdata[47:39] || ~|m_axis_tdata[47:39]) &&
      (&m_axis_tdata[63:55] || ~|m_axis_tdata[63:55]))
    else $error("wireless haptic outside int8 range");

endmodule

// File: tb/ath_stream_checker.sv
`timescale 1ns / 100ps
// Checker for the audio-to-haptic high-pass block: follows the register writes and the
// input frames, computes the output words the block owes, and compares them as they leave.
// Depends on ath_pkg.
module ath_stream_checker
  import ath_pkg::*;
#(
  parameter int PACKET_PAIRS       = 32,
  parameter int PACKETS_PER_BUFFER = 2,
  parameter int STATE_WIDTH        = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,

  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  // left_sample [15:0], right_sample [31:16]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // first_frame [0]
  input  logic                  s_axis_tuser,
  input  logic                  s_axis_tlast,

  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // audio_left [15:0], audio_right [31:16], haptic_left [47:32],
  // haptic_right [63:48], slot [69:64], zeros [71:70]
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  m_axis_tlast,

  output int unsigned           errors_o,
  output int unsigned           words_due_o
);

  localparam int unsigned TOTAL_SLOTS = PACKET_PAIRS * PACKETS_PER_BUFFER;
  localparam longint STATE_MAX = (longint'(1) <<< (STATE_WIDTH - 1)) - 1;
  localparam longint STATE_MIN = -STATE_MAX - 1;
  localparam longint Q15_MAX = 32767;
  localparam longint Q15_MIN = -32768;
  localparam longint INT8_SPAN_LO = longint'(INT8_MIN) * (longint'(1) <<< HAPTIC_FRAC);
  localparam longint INT8_SPAN_HI = longint'(-INT8_MIN - 1) * (longint'(1) <<< HAPTIC_FRAC);

  typedef struct {
    logic signed [SAMPLE_W-1:0] audio_left;
    logic signed [SAMPLE_W-1:0] audio_right;
    logic signed [SAMPLE_W-1:0] haptic_left;
    logic signed [SAMPLE_W-1:0] haptic_right;
    logic [SLOT_W-1:0]          slot;
    logic                       packet_last;
  } haptic_word_t;

  // Register copies, starting from their reset values.
  logic               wireless       = 1'b0;
  logic [GAIN_W-1:0]  gain           = GAIN_RESET;
  logic [ALPHA_W-1:0] alpha_wired    = ALPHA_RESET;
  logic [ALPHA_W-1:0] alpha_wireless = ALPHA_RESET;
  logic [DEC_W-1:0]   decimation     = DEC_RESET;

  longint      lp_left    = 0;
  longint      lp_right   = 0;
  int unsigned decim_pos  = 0;
  int unsigned slots_used = 0;

  haptic_word_t words_due[$];
  int unsigned  mismatch_count = 0;

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // One-pole low-pass step in Q.15 with a Q0.16 factor, rounded toward minus infinity.
  function automatic longint lowpass_next(input longint x, input longint s, input longint a);
    longint acc;
    acc = (65536 - a) * x + a * s;
    return clamp(acc >>> ALPHA_FRAC, STATE_MIN, STATE_MAX);
  endfunction

  // Scale a Q.15 high-pass value to int8, truncating toward zero.
  function automatic longint to_int8(input longint hp);
    longint v;
    v = clamp(hp * HAPTIC_SCALE, INT8_SPAN_LO, INT8_SPAN_HI);
    return (v >= 0) ? (v >>> HAPTIC_FRAC) : -((-v) >>> HAPTIC_FRAC);
  endfunction

  function automatic logic ends_packet(input int unsigned slot);
    return (slot % PACKET_PAIRS) == PACKET_PAIRS - 1;
  endfunction

  task automatic queue_word(input longint al, input longint ar, input longint hl,
                            input longint hr, input int unsigned slot, input logic plast);
    haptic_word_t w;
    w.audio_left   = al[SAMPLE_W-1:0];
    w.audio_right  = ar[SAMPLE_W-1:0];
    w.haptic_left  = hl[SAMPLE_W-1:0];
    w.haptic_right = hr[SAMPLE_W-1:0];
    w.slot         = slot[SLOT_W-1:0];
    w.packet_last  = plast;
    words_due = {words_due, w};
  endtask

  task automatic highpass_frame(input logic [IN_DATA_W-1:0] data, input logic first,
                                input logic last);
    longint      l;
    longint      r;
    longint      gl;
    longint      gr;
    int unsigned d;
    l = $signed(data[SAMPLE_W-1:0]);
    r = $signed(data[IN_DATA_W-1:SAMPLE_W]);
    if (first) begin
      decim_pos  = 0;
      slots_used = 0;
    end
    if (!wireless) begin
      gl = (l * longint'(gain)) >>> GAIN_FRAC;
      gr = (r * longint'(gain)) >>> GAIN_FRAC;
      lp_left  = lowpass_next(gl, lp_left, longint'(alpha_wired));
      lp_right = lowpass_next(gr, lp_right, longint'(alpha_wired));
      queue_word(clamp(gl, Q15_MIN, Q15_MAX), clamp(gr, Q15_MIN, Q15_MAX),
                 clamp(gl - lp_left, Q15_MIN, Q15_MAX),
                 clamp(gr - lp_right, Q15_MIN, Q15_MAX), 0, 1'b0);
    end else begin
      // Decimation of zero acts as one and anything past the maximum as the maximum.
      d = (decimation == 0) ? 1 : ((decimation > DEC_MAX) ? DEC_MAX : decimation);
      if (decim_pos == 0) begin
        lp_left  = lowpass_next(l, lp_left, longint'(alpha_wireless));
        lp_right = lowpass_next(r, lp_right, longint'(alpha_wireless));
        // Once the buffer is full, kept pairs are dropped but the filter still runs.
        if (slots_used < TOTAL_SLOTS) begin
          queue_word(0, 0, to_int8(l - lp_left), to_int8(r - lp_right), slots_used,
                     ends_packet(slots_used));
          slots_used++;
        end
      end
      decim_pos = (decim_pos + 1 >= d) ? 0 : decim_pos + 1;
      if (last) begin
        while (slots_used < TOTAL_SLOTS) begin
          queue_word(0, 0, 0, 0, slots_used, ends_packet(slots_used));
          slots_used++;
        end
      end
    end
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    haptic_word_t w;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_WIRELESS_MODE:  wireless       = cfg_data_i[0];
          CFG_VOLUME_GAIN:    gain           = cfg_data_i;
          CFG_ALPHA_WIRED:    alpha_wired    = cfg_data_i;
          CFG_ALPHA_WIRELESS: alpha_wireless = cfg_data_i;
          CFG_DECIMATION:     decimation     = cfg_data_i[DEC_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        highpass_frame(s_axis_tdata, s_axis_tuser, s_axis_tlast);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (words_due.size() == 0) begin
          $error("output word with nothing due: data %h last %b", m_axis_tdata, m_axis_tlast);
          mismatch_count++;
        end else begin
          w = words_due.pop_front();
          check_field("audio_left", w.audio_left, $signed(m_axis_tdata[15:0]));
          check_field("audio_right", w.audio_right, $signed(m_axis_tdata[31:16]));
          check_field("haptic_left", w.haptic_left, $signed(m_axis_tdata[47:32]));
          check_field("haptic_right", w.haptic_right, $signed(m_axis_tdata[63:48]));
          check_field("slot", w.slot, m_axis_tdata[69:64]);
          check_field("packet_last", w.packet_last, m_axis_tlast);
        end
      end
    end
    words_due_o <= words_due.size();
    errors_o    <= mismatch_count;
  end

endmodule

// File: tb/tb_audio_to_haptic_highpass.sv
`timescale 1ns / 100ps
// Top of the audio-to-haptic high-pass testbench: clock, reset, register writes, frame
// stimulus with bursts and gaps, output stalls, and the verdict. Depends on ath_pkg,
// audio_to_haptic_highpass and ath_stream_checker.
module tb_audio_to_haptic_highpass;
  import ath_pkg::*;

  localparam int PACKET_PAIRS       = 32;
  localparam int PACKETS_PER_BUFFER = 2;
  localparam int STATE_WIDTH        = 24;

  localparam int unsigned RANDOM_FRAMES = 248;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned DRAIN_LIMIT   = 20000;
  localparam int unsigned TIMEOUT_NS    = 20_000_000;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [IN_DATA_W-1:0]  in_data  = '0;
  logic                  in_first = 1'b0;
  logic                  in_last  = 1'b0;

  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [OUT_DATA_W-1:0] out_data;
  logic                  out_last;

  int unsigned mismatches;
  int unsigned words_due;

  int unsigned burst_left    = 0;
  int unsigned random_frames = 0;
  logic        cur_wireless  = 1'b0;
  logic [DEC_W-1:0] cur_decimation = DEC_RESET;

  logic [15:0] stall_pattern = 16'hFFFF;
  int unsigned stall_age     = 0;

  always #2 clk = ~clk;

  audio_to_haptic_highpass #(
    .PACKET_PAIRS      (PACKET_PAIRS),
    .PACKETS_PER_BUFFER(PACKETS_PER_BUFFER),
    .STATE_WIDTH       (STATE_WIDTH)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .s_axis_tvalid(in_valid),
    .s_axis_tready(in_ready),
    .s_axis_tdata (in_data),
    .s_axis_tuser (in_first),
    .s_axis_tlast (in_last),
    .m_axis_tvalid(out_valid),
    .m_axis_tready(out_ready),
    .m_axis_tdata (out_data),
    .m_axis_tlast (out_last)
  );

  ath_stream_checker #(
    .PACKET_PAIRS      (PACKET_PAIRS),
    .PACKETS_PER_BUFFER(PACKETS_PER_BUFFER),
    .STATE_WIDTH       (STATE_WIDTH)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .s_axis_tvalid(in_valid),
    .s_axis_tready(in_ready),
    .s_axis_tdata (in_data),
    .s_axis_tuser (in_first),
    .s_axis_tlast (in_last),
    .m_axis_tvalid(out_valid),
    .m_axis_tready(out_ready),
    .m_axis_tdata (out_data),
    .m_axis_tlast (out_last),
    .errors_o     (mismatches),
    .words_due_o  (words_due)
  );

  // The output side rotates a stall pattern that is swapped whenever its random age runs out;
  // an all-ones pattern gives stretches without back-pressure.
  always @(posedge clk) begin
    if (stall_age == 0) begin
      stall_age <= $urandom_range(300, 30);
      case ($urandom_range(3, 0))
        0, 1:    stall_pattern <= 16'hFFFF;
        2:       stall_pattern <= 16'($urandom() | 1);
        default: stall_pattern <= 16'(($urandom() & $urandom() & $urandom()) | 1);
      endcase
    end else begin
      stall_age     <= stall_age - 1;
      stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
    end
    out_ready <= stall_pattern[0];
  end

  function automatic logic signed [15:0] rand_sample();
    logic signed [15:0] v;
    case ($urandom_range(5, 0))
      0:       v = 16'sh7FFF;
      1:       v = 16'sh8000;
      2:       v = 16'($urandom_range(16, 0)) - 16'd8;
      default: v = 16'($urandom());
    endcase
    return v;
  endfunction

  function automatic logic [15:0] rand_level(input logic [15:0] mid);
    case ($urandom_range(3, 0))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return mid;
      default: return 16'($urandom());
    endcase
  endfunction

  // Leaves valid high so that register writes can follow each other back to back.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(input logic wireless, input logic [15:0] gain,
                           input logic [15:0] alpha_w, input logic [15:0] alpha_wl,
                           input logic [DEC_W-1:0] decimation);
    write_reg(CFG_WIRELESS_MODE, {15'd0, wireless});
    write_reg(CFG_VOLUME_GAIN, gain);
    write_reg(CFG_ALPHA_WIRED, alpha_w);
    write_reg(CFG_ALPHA_WIRELESS, alpha_wl);
    write_reg(CFG_DECIMATION, {{(CFG_DATA_W - DEC_W){1'b0}}, decimation});
    cfg_valid <= 1'b0;
    cur_wireless   = wireless;
    cur_decimation = decimation;
    @(posedge clk);
  endtask

  task automatic send_frame(input logic signed [15:0] left, input logic signed [15:0] right,
                            input logic first, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(16, 1);
    end
    burst_left--;
    in_data  <= {right, left};
    in_first <= first;
    in_last  <= last;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // Registers may change only once every owed word is out; a skipped frame owes
  // nothing yet may still be in flight, hence the extra cycles.
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure_random();
    logic [DEC_W-1:0] dec;
    case ($urandom_range(7, 0))
      0:       dec = 7'd0;
      1, 2:    dec = 7'd1;
      3:       dec = 7'd2;
      4:       dec = 7'd3;
      5:       dec = 7'd64;
      6:       dec = 7'd127;
      default: dec = DEC_W'($urandom_range(64, 1));
    endcase
    configure($urandom_range(2, 0) != 0, rand_level(16'd4096), rand_level(16'd32768),
              rand_level(16'd32768), dec);
  endtask

  // Mostly well-formed buffers; some lack a first or last flag, some carry noise flags.
  // With every frame kept, an occasional long buffer overruns the slots.
  task automatic send_buffer();
    int unsigned len;
    int unsigned shape;
    logic        is_first;
    logic        is_last;
    shape = $urandom_range(9, 0);
    len = (cur_decimation <= 7'd1 && $urandom_range(4, 0) == 0) ?
          $urandom_range(70, 65) : $urandom_range(12, 1);
    for (int i = 0; i < len; i++) begin
      case (shape)
        0: begin
          is_first = $urandom_range(3, 0) == 0;
          is_last  = $urandom_range(3, 0) == 0;
        end
        1: begin
          is_first = 1'b0;
          is_last  = (i == len - 1);
        end
        2: begin
          is_first = (i == 0);
          is_last  = 1'b0;
        end
        default: begin
          is_first = (i == 0);
          is_last  = (i == len - 1);
        end
      endcase
      send_frame(rand_sample(), rand_sample(), is_first, is_last);
      random_frames++;
    end
  endtask

  initial begin
    #(TIMEOUT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int unsigned phase_len;
    int unsigned phase_start;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: wired, unity gain, half smoothing. The last flag is ignored here.
    send_frame(16'sh7FFF, 16'sh8000, 1'b1, 1'b0);
    send_frame(16'sh8000, 16'sh7FFF, 1'b0, 1'b0);
    send_frame(16'sh0000, 16'sh0000, 1'b0, 1'b0);
    send_frame(-16'sd1, 16'sd1, 1'b0, 1'b0);
    send_frame(16'sh7FFF, 16'sh7FFF, 1'b0, 1'b1);

    // Wired, full gain so the audio clamps, and no smoothing.
    settle();
    configure(1'b0, 16'hFFFF, 16'h0000, 16'h0000, 7'd1);
    send_frame(16'sh7FFF, 16'sh8000, 1'b0, 1'b0);
    send_frame(16'sh8000, 16'sh8000, 1'b1, 1'b0);
    send_frame(16'sd1, -16'sd1, 1'b0, 1'b0);

    // Wired, zero gain, the state held almost entirely.
    settle();
    configure(1'b0, 16'h0000, 16'hFFFF, 16'hFFFF, 7'd1);
    send_frame(16'sh7FFF, 16'sh8000, 1'b0, 1'b0);
    send_frame(16'sd100, -16'sd100, 1'b0, 1'b0);

    // Wireless, every frame kept: padding, pairs dropped after padding until the next
    // first flag, then first and last on one frame.
    settle();
    configure(1'b1, 16'h1000, 16'h8000, 16'hFFFF, 7'd1);
    send_frame(16'sh7FFF, 16'sh8000, 1'b1, 1'b0);
    send_frame(16'sh8000, 16'sh7FFF, 1'b0, 1'b0);
    send_frame(16'sh0000, 16'sh0000, 1'b0, 1'b1);
    send_frame(16'sd1000, -16'sd1000, 1'b0, 1'b0);
    send_frame(16'sd5, 16'sd5, 1'b0, 1'b1);
    send_frame(16'sh8000, 16'sh7FFF, 1'b1, 1'b1);

    // Wireless with a zero decimation, then 127, above the maximum of 64.
    settle();
    configure(1'b1, 16'h1000, 16'h8000, 16'h0000, 7'd0);
    send_frame(16'sh7FFF, 16'sh7FFF, 1'b1, 1'b0);
    send_frame(16'sh8000, 16'sh8000, 1'b0, 1'b0);
    send_frame(16'sd123, -16'sd456, 1'b0, 1'b1);
    settle();
    configure(1'b1, 16'h1000, 16'h8000, 16'h4000, 7'd127);
    send_frame(16'sh8000, 16'sh7FFF, 1'b1, 1'b0);
    send_frame(16'sd1, 16'sd2, 1'b0, 1'b0);
    send_frame(16'sd3, 16'sd4, 1'b0, 1'b1);

    while (random_frames < RANDOM_FRAMES) begin
      settle();
      configure_random();
      phase_len   = $urandom_range(50, 20);
      phase_start = random_frames;
      while (random_frames - phase_start < phase_len && random_frames < RANDOM_FRAMES) begin
        if (cur_wireless) begin
          send_buffer();
        end else begin
          send_frame(rand_sample(), rand_sample(), $urandom_range(7, 0) == 0,
                     $urandom_range(7, 0) == 0);
          random_frames++;
        end
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < DRAIN_LIMIT && words_due != 0; i++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (words_due != 0) begin
      $error("%0d output words never arrived", words_due);
    end
    if (mismatches == 0 && words_due == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/ath_pkg.sv
rtl/core/ath_cfg.sv
rtl/core/ath_ctrl.sv
rtl/core/ath_dp.sv
rtl/core/audio_to_haptic_highpass.sv
tb/ath_stream_checker.sv
tb/tb_audio_to_haptic_highpass.sv
